[src/bounded_stable_priority_queue_top_macros.svh]
// Assertion macros for the queue checker.
// Every assertion samples on the rising edge of clk and is held off
// while rst_n is low.
`ifndef BOUNDED_STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH
`define BOUNDED_STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH

// Plain property that must hold at every sampled edge.
`define BSPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bspq check failed");

// Property that must hold whenever a condition is seen.
`define BSPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bspq implication failed");

// Property that must hold in the cycle after a condition is seen.
`define BSPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bspq next-cycle check failed");

`endif

[src/bspq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bspq_pkg
// Shared types and codes for the bounded stable priority queue.
// ----------------------------------------------------------------------------
package bspq_pkg;

  localparam int ACT_W = 2;

  // Operation codes carried by one input beat.
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD = 2'd0,
    ACT_POP = 2'd1,
    ACT_DIS = 2'd2,
    ACT_NOP = 2'd3
  } action_t;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_READ = 3'b100
  } state_t;

endpackage
`default_nettype wire

[src/bspq_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bspq_in_if
// Request channel: one beat carries an operation, a tag and a level.
// ----------------------------------------------------------------------------
interface bspq_in_if
  import bspq_pkg::*;
#(
  parameter int TAG_WIDTH = 16,
  parameter int LVL_W     = 2
) ();
  logic                 valid;
  logic                 ready;
  logic [ACT_W-1:0]     action;
  logic [TAG_WIDTH-1:0] task_tag;
  logic [LVL_W-1:0]     task_level;

  modport source (output valid, action, task_tag, task_level, input ready);
  modport sink   (input valid, action, task_tag, task_level, output ready);
endinterface
`default_nettype wire

[src/bspq_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bspq_out_if
// Result channel: one beat per request, with status after the request.
// ----------------------------------------------------------------------------
interface bspq_out_if #(
  parameter int TAG_WIDTH = 16,
  parameter int LVL_W     = 2,
  parameter int CNT_W     = 5
) ();
  logic                 valid;
  logic                 ready;
  logic                 add_accepted;
  logic                 pop_valid;
  logic [TAG_WIDTH-1:0] popped_tag;
  logic [LVL_W-1:0]     popped_level;
  logic [CNT_W-1:0]     entry_count;
  logic                 queue_empty;
  logic                 finished;

  modport source (output valid, add_accepted, pop_valid, popped_tag, popped_level,
                  entry_count, queue_empty, finished, input ready);
  modport sink   (input valid, add_accepted, pop_valid, popped_tag, popped_level,
                  entry_count, queue_empty, finished, output ready);
endinterface
`default_nettype wire

[src/bspq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bspq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bspq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[src/bspq_sched.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bspq_sched
// Per-level ring pointers and counts; picks the highest non-empty level and
// forms the RAM addresses for a push into a level and a pop from the head.
// ----------------------------------------------------------------------------
module bspq_sched #(
  parameter int QUEUE_DEPTH = 16,
  parameter int LEVEL_COUNT = 4,
  localparam int LVL_W  = $clog2(LEVEL_COUNT),
  localparam int PTR_W  = $clog2(QUEUE_DEPTH),
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1),
  localparam int ADDR_W = LVL_W + PTR_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [LVL_W-1:0]  push_level,
  input  wire logic              pop,
  output logic      [LVL_W-1:0]  top_level,
  output logic      [ADDR_W-1:0] wr_addr,
  output logic      [ADDR_W-1:0] rd_addr
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [PTR_W-1:0] head_r [LEVEL_COUNT];
  logic [PTR_W-1:0] tail_r [LEVEL_COUNT];
  logic [CNT_W-1:0] cnt_r  [LEVEL_COUNT];

  // Pick the highest level that holds an entry
  always_comb begin
    top_level = '0;
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      if (cnt_r[l] != '0) begin
        top_level = LVL_W'(l);
      end
    end
  end

  assign wr_addr = {push_level, tail_r[push_level]};
  assign rd_addr = {top_level, head_r[top_level]};

  // Advance tail on push, head on pop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVEL_COUNT; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else if (push) begin
      tail_r[push_level] <= (tail_r[push_level] == PTR_LAST) ? '0
                                                             : tail_r[push_level] + 1'b1;
      cnt_r[push_level]  <= cnt_r[push_level] + 1'b1;
    end else if (pop) begin
      head_r[top_level] <= (head_r[top_level] == PTR_LAST) ? '0
                                                           : head_r[top_level] + 1'b1;
      cnt_r[top_level]  <= cnt_r[top_level] - 1'b1;
    end
  end

endmodule
`default_nettype wire

[src/bounded_stable_priority_queue_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_stable_priority_queue_top
// Bounded priority queue of task tags, FIFO order within a level.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  : request beats (action, task_tag, task_level), valid/ready.
//             action 0 adds, 1 pops the head, 2 disables further adds.
//   out_bus : exactly one result beat per request, in request order.
//   cfg_we/cfg_wdata : write queue_capacity; only while the block is idle.
// Entries live in one RAM split into one ring per level; pointers and counts
// per level sit in flops. A pop reads the head of the highest non-empty ring.
// An add, disable or empty pop is carried out in ST_EXEC and its result
// goes to the output register; a pop that returns an entry first passes
// ST_READ for the registered RAM read. One request is in work at a time;
// the next is taken once the sequencer has returned to ST_IDLE.
// The result sits in an output register; the next request is taken while it
// waits. If the receiver stalls, the following result holds in the sequencer
// until the register frees. Reset (synchronous, rst_n low) empties the queue,
// re-enables adds and sets the capacity to QUEUE_DEPTH; RAM is not cleared.
// ----------------------------------------------------------------------------
module bounded_stable_priority_queue_top
  import bspq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int LEVEL_COUNT = 4,
  parameter int TAG_WIDTH   = 16,
  localparam int LVL_W  = $clog2(LEVEL_COUNT),
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1),
  localparam int PTR_W  = $clog2(QUEUE_DEPTH),
  localparam int ADDR_W = LVL_W + PTR_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  bspq_in_if.sink               in_bus,
  bspq_out_if.source            out_bus,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(QUEUE_DEPTH);
  localparam logic [LVL_W-1:0] LVL_MAX_C = LVL_W'(LEVEL_COUNT - 1);

  state_t               state_r, state_nxt;
  logic [ACT_W-1:0]     act_r;
  logic [TAG_WIDTH-1:0] tag_r;
  logic [LVL_W-1:0]     lvl_r, lvl_in;
  logic [LVL_W-1:0]     plvl_r, plvl_nxt;
  logic [CNT_W-1:0]     held_r, held_nxt;
  logic                 en_r, en_nxt;
  logic [CNT_W-1:0]     cap_r, eff_cap;

  logic                 out_valid_r, out_valid_nxt;
  logic                 o_acc_r, o_acc_nxt;
  logic                 o_pv_r, o_pv_nxt;
  logic [TAG_WIDTH-1:0] o_tag_r, o_tag_nxt;
  logic [LVL_W-1:0]     o_lvl_r, o_lvl_nxt;
  logic [CNT_W-1:0]     o_cnt_r, o_cnt_nxt;
  logic                 o_emp_r, o_emp_nxt;
  logic                 o_fin_r, o_fin_nxt;

  logic                 in_fire, out_free;
  logic                 add_ok, pop_go;
  logic                 sch_push, sch_pop;
  logic [LVL_W-1:0]     top_level;
  logic [ADDR_W-1:0]    wr_addr, rd_addr;
  logic [TAG_WIDTH-1:0] rd_data;
  action_t              act;

  assign in_bus.ready = (state_r == ST_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;
  assign act          = action_t'(act_r);
  assign eff_cap      = (cap_r > DEPTH_C) ? DEPTH_C : cap_r;
  assign add_ok       = (act == ACT_ADD) && en_r && (held_r < eff_cap);
  assign pop_go       = (act == ACT_POP) && (held_r != '0);

  // Saturate out-of-range levels
  assign lvl_in = (in_bus.task_level > LVL_MAX_C) ? LVL_MAX_C : in_bus.task_level;

  bspq_sched #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_sched (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (sch_push),
    .push_level (lvl_r),
    .pop        (sch_pop),
    .top_level  (top_level),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr)
  );

  bspq_ram #(
    .WIDTH (TAG_WIDTH),
    .DEPTH (2 ** ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (sch_push),
    .waddr (wr_addr),
    .wdata (tag_r),
    .re    (sch_pop),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Sequencer: execute one request, then deliver its result beat
  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    en_nxt        = en_r;
    plvl_nxt      = plvl_r;
    sch_push      = 1'b0;
    sch_pop       = 1'b0;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    o_acc_nxt     = o_acc_r;
    o_pv_nxt      = o_pv_r;
    o_tag_nxt     = o_tag_r;
    o_lvl_nxt     = o_lvl_r;
    o_cnt_nxt     = o_cnt_r;
    o_emp_nxt     = o_emp_r;
    o_fin_nxt     = o_fin_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (pop_go) begin
          // Issue the head read and retire the entry
          sch_pop   = 1'b1;
          held_nxt  = held_r - 1'b1;
          plvl_nxt  = top_level;
          state_nxt = ST_READ;
        end else if (out_free) begin
          if (add_ok) begin
            sch_push = 1'b1;
            held_nxt = held_r + 1'b1;
          end
          if (act == ACT_DIS) begin
            en_nxt = 1'b0;
          end
          out_valid_nxt = 1'b1;
          o_acc_nxt     = add_ok;
          o_pv_nxt      = 1'b0;
          o_tag_nxt     = '0;
          o_lvl_nxt     = '0;
          o_cnt_nxt     = held_nxt;
          o_emp_nxt     = (held_nxt == '0);
          o_fin_nxt     = (held_nxt == '0) && !en_nxt;
          state_nxt     = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_acc_nxt     = 1'b0;
          o_pv_nxt      = 1'b1;
          o_tag_nxt     = rd_data;
          o_lvl_nxt     = plvl_r;
          o_cnt_nxt     = held_r;
          o_emp_nxt     = (held_r == '0);
          o_fin_nxt     = (held_r == '0) && !en_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      en_r        <= 1'b1;
      cap_r       <= DEPTH_C;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      en_r        <= en_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Capture request beat and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r <= in_bus.action;
      tag_r <= in_bus.task_tag;
      lvl_r <= lvl_in;
    end
    plvl_r  <= plvl_nxt;
    o_acc_r <= o_acc_nxt;
    o_pv_r  <= o_pv_nxt;
    o_tag_r <= o_tag_nxt;
    o_lvl_r <= o_lvl_nxt;
    o_cnt_r <= o_cnt_nxt;
    o_emp_r <= o_emp_nxt;
    o_fin_r <= o_fin_nxt;
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.add_accepted = o_acc_r;
  assign out_bus.pop_valid    = o_pv_r;
  assign out_bus.popped_tag   = o_tag_r;
  assign out_bus.popped_level = o_lvl_r;
  assign out_bus.entry_count  = o_cnt_r;
  assign out_bus.queue_empty  = o_emp_r;
  assign out_bus.finished     = o_fin_r;

endmodule
`default_nettype wire

[src/bspq_check.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bspq_check
// Port-level checks on the result channel of the priority queue.
// ----------------------------------------------------------------------------
`include "bounded_stable_priority_queue_top_macros.svh"

module bspq_check #(
  parameter int TAG_WIDTH = 16,
  parameter int LVL_W     = 2,
  parameter int CNT_W     = 5
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 add_accepted,
  input wire logic                 pop_valid,
  input wire logic [TAG_WIDTH-1:0] popped_tag,
  input wire logic [LVL_W-1:0]     popped_level,
  input wire logic [CNT_W-1:0]     entry_count,
  input wire logic                 queue_empty,
  input wire logic                 finished
);

  // A stalled result beat stays up
  `BSPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A beat never both stores and removes an entry
  `BSPQ_ASSERT_IMP(a_add_xor_pop, out_valid, !(add_accepted && pop_valid))

  // Empty flag tracks the count
  `BSPQ_ASSERT_IMP(a_empty_cnt, out_valid, queue_empty == (entry_count == '0))

  // A beat without an entry carries zero payload
  `BSPQ_ASSERT_IMP(a_pop_zero, out_valid && !pop_valid,
                   popped_tag == '0 && popped_level == '0)

  // Finished only when the queue is drained
  `BSPQ_ASSERT_IMP(a_fin_empty, out_valid && finished, queue_empty)

endmodule

bind bounded_stable_priority_queue_top bspq_check #(
  .TAG_WIDTH (TAG_WIDTH),
  .LVL_W     (LVL_W),
  .CNT_W     (CNT_W)
) u_bspq_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .add_accepted (out_bus.add_accepted),
  .pop_valid    (out_bus.pop_valid),
  .popped_tag   (out_bus.popped_tag),
  .popped_level (out_bus.popped_level),
  .entry_count  (out_bus.entry_count),
  .queue_empty  (out_bus.queue_empty),
  .finished     (out_bus.finished)
);
`default_nettype wire
